// ===== rtl/core/fcs_pkg.sv =====
// Shared constants, types and the modulo-255 adder for the Fletcher checksum block.
package fcs_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam logic [8:0] MOD_VAL   = 9'd255;
    localparam logic [8:0] FILL_BASE = 9'd510;
    localparam logic [7:0] MOD_BYTE  = 8'd255;

    typedef struct packed {
        logic [7:0] sum_first;
        logic [7:0] sum_second;
        logic [7:0] dist_mod;
        logic       off_nz;
    } t_msg_sums;

    typedef struct packed {
        logic [15:0] checksum_value;
        logic        checksum_is_zero;
        logic [7:0]  fill_first;
        logic [7:0]  fill_second;
    } t_result;

    // Valid whenever a + b stays below twice the modulus.
    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MOD_VAL) begin
            s = s - MOD_VAL;
        end
        return s[7:0];
    endfunction

endpackage

// ===== rtl/core/fcs_fill.sv =====
// Result pipeline: forms the checksum and the two check bytes from the final sums.
module fcs_fill (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fcs_pkg::t_msg_sums i_sums,
    output logic              o_valid,
    input  logic              i_ready,
    output fcs_pkg::t_result  o_result
);
    import fcs_pkg::*;

    logic       rdy_out, rdy2, rdy1;
    logic       r_v1, r_v2, r_ov;
    t_msg_sums  r_s1;
    logic [15:0] r_prod;
    logic [7:0] r_sf2, r_ss2;
    logic       r_nz2;
    t_result    r_res;
    t_result    n_res;

    logic [7:0] prod_mod;
    logic [7:0] t_val;
    logic [7:0] iq;
    logic [8:0] ir_raw;
    logic [8:0] ir;

    assign rdy_out = !r_ov || i_ready;
    assign rdy2    = !r_v2 || rdy_out;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        prod_mod = add_mod255(r_prod[15:8], r_prod[7:0]);
        t_val    = add_mod255(prod_mod, MOD_BYTE - r_ss2);
        iq       = (t_val == 8'd0) ? MOD_BYTE : t_val;
        ir_raw   = FILL_BASE - {1'b0, r_sf2} - {1'b0, iq};
        ir       = (ir_raw > MOD_VAL) ? (ir_raw - MOD_VAL) : ir_raw;

        n_res.checksum_value   = {r_ss2, r_sf2};
        n_res.checksum_is_zero = (r_ss2 == 8'd0) && (r_sf2 == 8'd0);
        n_res.fill_first       = r_nz2 ? iq : 8'd0;
        n_res.fill_second      = r_nz2 ? ir[7:0] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy_out) begin
                r_ov <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1 <= i_sums;
        end
        if (rdy2 && r_v1) begin
            r_prod <= {8'd0, r_s1.dist_mod} * {8'd0, r_s1.sum_first};
            r_sf2  <= r_s1.sum_first;
            r_ss2  <= r_s1.sum_second;
            r_nz2  <= r_s1.off_nz;
        end
        if (rdy_out && r_v2) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

endmodule

// ===== rtl/core/fletcher_checksum_with_insertion.sv =====
// Top level of the Fletcher checksum block with check-byte insertion.
// The block takes one message byte per cycle while input ready is high, and keeps the two
// modulo-255 sums, the byte count and the position modulo 255 in registers updated on each
// accepted word. A word flagged as the last byte hands the final sums to a three-register
// result pipeline (operands, 8 by 8 product, reduction), whose output register presents its
// result, and the accumulators are already clear for the next message in the following
// cycle. Input ready falls only when that result pipeline is full and the output is stalled.
// The offset register is written through its own channel, which is always ready.
module fletcher_checksum_with_insertion #(
    parameter int COUNT_BITS = fcs_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_checksum_value,
    output logic        o_checksum_is_zero,
    output logic [7:0]  o_fill_first,
    output logic [7:0]  o_fill_second,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import fcs_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [15:0]           r_check_offset;
    logic [7:0]            r_off_mod;
    logic [7:0]            r_sum_first, r_sum_second;
    logic [COUNT_BITS-1:0] r_byte_index;
    logic [7:0]            r_pos_mod;

    logic [7:0]  n_sum_first, n_sum_second;
    logic [7:0]  n_len_mod;
    logic [7:0]  byte_in;
    logic [CMP_W-1:0] pos_w, off_w, off_m1_w;
    logic        off_nz;
    logic        accept;
    logic        fill_ready;
    t_msg_sums   sums;
    t_result     result;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = fill_ready;

    always_comb begin
        off_nz   = (r_check_offset != 16'd0);
        pos_w    = CMP_W'(r_byte_index);
        off_w    = CMP_W'(r_check_offset);
        off_m1_w = off_w - CMP_W'(1);
        byte_in  = i_data_byte;
        if (off_nz && ((pos_w == off_m1_w) || (pos_w == off_w))) begin
            byte_in = 8'd0;
        end
        n_sum_first  = add_mod255(r_sum_first, byte_in);
        n_sum_second = add_mod255(r_sum_second, n_sum_first);
        n_len_mod    = (&r_byte_index) ? 8'd0 : add_mod255(r_pos_mod, 8'd1);

        sums.sum_first  = n_sum_first;
        sums.sum_second = n_sum_second;
        sums.dist_mod   = add_mod255(n_len_mod, MOD_BYTE - r_off_mod);
        sums.off_nz     = off_nz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_offset <= 16'd0;
            r_off_mod      <= 8'd0;
            r_sum_first    <= 8'd0;
            r_sum_second   <= 8'd0;
            r_byte_index   <= '0;
            r_pos_mod      <= 8'd0;
        end else begin
            if (i_cfg_valid) begin
                r_check_offset <= i_cfg_data;
                r_off_mod      <= add_mod255(i_cfg_data[15:8], i_cfg_data[7:0]);
            end
            if (accept) begin
                if (i_last_byte) begin
                    r_sum_first  <= 8'd0;
                    r_sum_second <= 8'd0;
                    r_byte_index <= '0;
                    r_pos_mod    <= 8'd0;
                end else begin
                    r_sum_first  <= n_sum_first;
                    r_sum_second <= n_sum_second;
                    r_byte_index <= r_byte_index + COUNT_BITS'(1);
                    r_pos_mod    <= n_len_mod;
                end
            end
        end
    end

    fcs_fill u_fill (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid && i_last_byte),
        .o_ready  (fill_ready),
        .i_sums   (sums),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (result)
    );

    assign o_checksum_value   = result.checksum_value;
    assign o_checksum_is_zero = result.checksum_is_zero;
    assign o_fill_first       = result.fill_first;
    assign o_fill_second      = result.fill_second;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_byte |=> (r_sum_first == 8'd0) && (r_sum_second == 8'd0)
            && (r_byte_index == '0) && (r_pos_mod == 8'd0))
        else $error("Message state not cleared after the last word.");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_checksum_is_zero == (o_checksum_value == 16'd0)))
        else $error("Zero flag disagrees with the checksum.");

    a_verify_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_check_offset == 16'd0)
            |-> (o_fill_first == 8'd0) && (o_fill_second == 8'd0))
        else $error("Check bytes produced with insertion disabled.");

    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_check_offset != 16'd0) |-> (o_fill_first != 8'd0))
        else $error("First check byte is zero with insertion enabled.");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the Fletcher checksum block with check-byte insertion.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcs_pkg::*;

    localparam time         HALF_PERIOD  = 10ns;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          TAIL_CYCLES  = 8;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          PHASES       = 16;
    localparam int          PHASE_BYTES  = 56;
    localparam int          PRINT_LIMIT  = 40;
    localparam int unsigned MODULUS      = MOD_VAL;
    localparam int unsigned FILL_TOTAL   = FILL_BASE;

    typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} t_flow;

    typedef struct {
        bit          is_write;
        logic [15:0] offset;
        logic [7:0]  data;
        logic        last;
        bit          known;
        t_result     result;
    } t_script_row;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_in_valid         = 1'b0;
    logic [7:0]  i_data_byte        = '0;
    logic        i_last_byte        = 1'b0;
    logic        i_out_ready        = 1'b0;
    logic        i_cfg_valid        = 1'b0;
    logic [15:0] i_cfg_data         = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [15:0] o_checksum_value;
    logic        o_checksum_is_zero;
    logic [7:0]  o_fill_first;
    logic [7:0]  o_fill_second;
    logic        o_cfg_ready;

    fletcher_checksum_with_insertion dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_checksum_value   (o_checksum_value),
        .o_checksum_is_zero (o_checksum_is_zero),
        .o_fill_first       (o_fill_first),
        .o_fill_second      (o_fill_second),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Shadow state of the checksum engine.
    logic [15:0] offset_reg = '0;
    logic [15:0] msg_pos    = '0;
    int unsigned acc_first  = 0;
    int unsigned acc_second = 0;

    t_result     awaited_checksums[$];
    t_result     want;
    int          mismatches      = 0;
    int          bytes_sent      = 0;
    int          messages_sent   = 0;
    int          checksums_seen  = 0;
    int          offsets_written = 0;
    int          src_idle_pct    = 0;
    int          snk_stall_pct   = 0;
    int          idle_run        = 0;
    int          hold_left       = 0;
    bit          hold_go         = 1'b0;
    bit          hold_taken      = 1'b0;

    t_script_row script [27];

    function automatic t_script_row wr(input logic [15:0] v);
        return '{1'b1, v, 8'h00, 1'b0, 1'b0, '0};
    endfunction

    function automatic t_script_row by(input logic [7:0] d, input logic l);
        return '{1'b0, 16'h0000, d, l, 1'b0, '0};
    endfunction

    function automatic t_script_row by_known(input logic [7:0] d, input t_result r);
        return '{1'b0, 16'h0000, d, 1'b1, 1'b1, r};
    endfunction

    function automatic logic [7:0] draw_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Folds one word into the running sums; returns 1 when the word closes a message.
    function automatic bit fold_byte(input logic [7:0] d, input logic l, output t_result r);
        int unsigned b;
        int unsigned len;
        int unsigned dist_mod;
        int unsigned t;
        int unsigned iq;
        int unsigned ir;
        logic [15:0] len16;
        b = d;
        r = '0;
        if (offset_reg != 16'd0 && (msg_pos + 16'd1 == offset_reg || msg_pos == offset_reg)) begin
            b = 0;
        end
        acc_first  = (acc_first + b) % MODULUS;
        acc_second = (acc_second + acc_first) % MODULUS;
        if (!l) begin
            msg_pos = msg_pos + 16'd1;
            return 1'b0;
        end
        r.checksum_value   = {acc_second[7:0], acc_first[7:0]};
        r.checksum_is_zero = (r.checksum_value == 16'd0);
        if (offset_reg != 16'd0) begin
            len16    = msg_pos + 16'd1;
            len      = len16;
            dist_mod = (len % MODULUS + MODULUS - offset_reg % MODULUS) % MODULUS;
            t        = (dist_mod * acc_first + MODULUS - acc_second) % MODULUS;
            iq       = (t == 0) ? MODULUS : t;
            ir       = FILL_TOTAL - acc_first - iq;
            if (ir > MODULUS) begin
                ir = ir - MODULUS;
            end
            r.fill_first  = iq[7:0];
            r.fill_second = ir[7:0];
        end
        acc_first  = 0;
        acc_second = 0;
        msg_pos    = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s got %0h, wanted %0h", $realtime, what, got, exp_val);
        end
    endtask

    task automatic set_flow(input t_flow f);
        case (f)
            FLOW_FREE: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            FLOW_SRC_IDLE: begin
                src_idle_pct  = 78;
                snk_stall_pct = 0;
            end
            FLOW_SNK_STALL: begin
                src_idle_pct  = 0;
                snk_stall_pct = 78;
            end
            default: begin
                src_idle_pct  = 9;
                snk_stall_pct = 9;
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] d, input logic l, input bit known,
                             input t_result typed);
        t_result r;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= l;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        if (fold_byte(d, l, r)) begin
            messages_sent++;
            awaited_checksums.push_back(known ? typed : r);
        end
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            push_byte(draw_byte(), i == len - 1, 1'b0, '0);
        end
    endtask

    task automatic set_offset(input logic [15:0] v);
        i_in_valid <= 1'b0;
        while (awaited_checksums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        offset_reg = v;
        offsets_written++;
    endtask

    // Result side: checks each delivered word and decides ready for the next cycle.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            checksums_seen++;
            if (awaited_checksums.size() == 0) begin
                report_mismatch("checksum with nothing awaited", o_checksum_value, 0);
            end else begin
                want = awaited_checksums.pop_front();
                if (o_checksum_value !== want.checksum_value) begin
                    report_mismatch("checksum_value", o_checksum_value, want.checksum_value);
                end
                if (o_checksum_is_zero !== want.checksum_is_zero) begin
                    report_mismatch("checksum_is_zero", o_checksum_is_zero,
                                    want.checksum_is_zero);
                end
                if (o_fill_first !== want.fill_first) begin
                    report_mismatch("fill_first", o_fill_first, want.fill_first);
                end
                if (o_fill_second !== want.fill_second) begin
                    report_mismatch("fill_second", o_fill_second, want.fill_second);
                end
            end
        end
        if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("Stalled for %0d cycles at %0t", idle_run, $realtime);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin
        int          len;
        int          pick;
        int          sent;
        logic [15:0] off;

        script = '{
            by_known(8'h00, t_result'{16'h0000, 1'b1, 8'd0, 8'd0}),
            by_known(8'hFF, t_result'{16'h0000, 1'b1, 8'd0, 8'd0}),
            by_known(8'hFE, t_result'{16'hFEFE, 1'b0, 8'd0, 8'd0}),
            by_known(8'h01, t_result'{16'h0101, 1'b0, 8'd0, 8'd0}),
            by(8'h80, 1'b0), by(8'h7F, 1'b1),
            wr(16'd1),
            by(8'hAA, 1'b0),
            by_known(8'hBB, t_result'{16'h0000, 1'b1, 8'd255, 8'd255}),
            by(8'h55, 1'b0), by(8'hC3, 1'b0), by(8'hFF, 1'b0), by(8'h01, 1'b1),
            wr(16'hFFFF),
            by(8'h12, 1'b0), by(8'hEF, 1'b0), by(8'h9A, 1'b1),
            wr(16'd5),
            by(8'h3C, 1'b0), by(8'hFF, 1'b0), by(8'h00, 1'b1),
            wr(16'd3),
            by(8'h11, 1'b0), by(8'h22, 1'b0), by(8'h33, 1'b0), by(8'h44, 1'b0),
            by(8'hFD, 1'b1)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_flow(FLOW_BOTH);
        foreach (script[k]) begin
            if (script[k].is_write) begin
                set_offset(script[k].offset);
            end else begin
                push_byte(script[k].data, script[k].last, script[k].known, script[k].result);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case ((p / 2) % 8)
                0: off = 16'd0;
                1: off = 16'd1;
                2: off = 16'($urandom_range(2, 6));
                3: off = 16'($urandom_range(1, 40));
                4: off = 16'hFFFF;
                5: off = 16'($urandom_range(65535));
                6: off = 16'd2;
                default: off = 16'($urandom_range(3, 12));
            endcase
            set_offset(off);
            set_flow(t_flow'(p % 4));
            if (p == 4) begin
                hold_go = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    len = $urandom_range(1, 8);
                end else if (pick < 95) begin
                    len = $urandom_range(9, 40);
                end else begin
                    len = $urandom_range(41, 200);
                end
                send_message(len);
                sent += len;
            end
        end

        i_in_valid <= 1'b0;
        while (awaited_checksums.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (awaited_checksums.size() != 0) begin
            report_mismatch("checksums never delivered", 0, awaited_checksums.size());
        end
        $display("Sent %0d bytes in %0d messages and checked %0d checksums.",
                 bytes_sent, messages_sent, checksums_seen);
        $display("The offset was set %0d times, from zero to 65535, under four flow patterns.",
                 offsets_written);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/fcs_pkg.sv
rtl/core/fcs_fill.sv
rtl/core/fletcher_checksum_with_insertion.sv
bench/tb.sv
